>>> rtl/mfbdr_pkg.sv
// Shared types and constants of the median-filtered boost duty regulator.
package mfbdr_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int WINDOW_SIZE_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int DUTY_W          = 20;
    localparam int SLOPE_W         = 17;
    localparam int GAIN_W          = 8;
    localparam int OFFSET_W        = 10;
    localparam int PWM_W           = 10;

    localparam logic [SAMPLE_W-1:0] SETPOINT_RST = 12'd550;
    localparam logic [GAIN_W-1:0]   GAIN_RST     = 8'd5;
    localparam logic [DUTY_W-1:0]   DUTY_MIN_RST = 20'((1000 * 5 * 1024) / 100);
    localparam logic [DUTY_W-1:0]   DUTY_MAX_RST = 20'((1000 * 90 * 1024) / 100);
    localparam logic [SLOPE_W-1:0]  SLOPE_RST    = 17'd17604;
    localparam logic [OFFSET_W-1:0] OFFSET_RST   = 10'd0;

    localparam logic [SAMPLE_W-1:0] MV_MAX     = 12'd4095;
    localparam logic [10:0]         DUTY_RECIP = 11'd1048;
    localparam logic [9:0]          DUTY_DIV   = 10'd1000;
    localparam logic [PWM_W-1:0]    PWM_MAX    = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_LOOP_GAIN  = 3'd1,
        REG_DUTY_MIN   = 3'd2,
        REG_DUTY_MAX   = 3'd3,
        REG_CAL_SLOPE  = 3'd4,
        REG_CAL_OFFSET = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                del;
        logic                ins;
        logic [SAMPLE_W-1:0] d;
        logic [SAMPLE_W-1:0] x;
    } t_cell_cmd;

endpackage

>>> rtl/median_filtered_boost_duty_regulator.sv
// Top level of the median-filtered boost duty regulator.
// Each accepted ADC sample enters a running window kept sorted by a row of cells; the
// window median is calibrated to millivolts and drives an integral duty accumulator
// clamped to [duty_min, duty_max]; each sample yields one result holding the PWM duty
// (accumulator / 1000, saturated at 1023) and the feedback voltage. One item is in work
// at a time: the delete in the cell row happens at the transfer, then come the insert,
// the calibration multiply, the error and gain multiply, the accumulate, the reciprocal
// multiply and the correction into the output register. A new sample is taken only once
// that result is in the output register, later when the output is stalled. The window and
// accumulator reset to zeros and 51200; configuration writes take effect at once and
// belong in idle.
module median_filtered_boost_duty_regulator
    import mfbdr_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PWM_W-1:0]      o_pwm_duty,
    output logic [SAMPLE_W-1:0]   o_feedback_mv,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INS  = 7'b0000010,
        S_MED  = 7'b0000100,
        S_ERR  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_setpoint;
    logic [GAIN_W-1:0]   r_gain;
    logic [DUTY_W-1:0]   r_duty_min;
    logic [DUTY_W-1:0]   r_duty_max;
    logic [SLOPE_W-1:0]  r_cal_slope;
    logic [OFFSET_W-1:0] r_cal_offset;

    logic [SAMPLE_W-1:0]       r_x;
    logic [28:0]               r_prod;
    logic [SAMPLE_W-1:0]       r_mv;
    logic signed [20:0]        r_gerr;
    logic [DUTY_W-1:0]         r_acc;
    logic [10:0]               r_q0;
    logic                      r_out_valid;
    logic [PWM_W-1:0]          r_pwm;
    logic [SAMPLE_W-1:0]       r_fb_mv;

    logic                      in_xfer;
    logic                      out_free;
    logic [SAMPLE_W-1:0]       median;

    logic [29:0]               rnd;
    logic [13:0]               scaled;
    logic signed [14:0]        mv_wide;
    logic [SAMPLE_W-1:0]       mv_sat;
    logic signed [12:0]        err;
    logic signed [20:0]        gerr;
    logic signed [21:0]        acc_sum;
    logic [DUTY_W-1:0]         acc_clamp;
    logic [30:0]               recip_prod;
    logic [DUTY_W-1:0]         q_back;
    logic [DUTY_W-1:0]         rem;
    logic [10:0]               q_full;
    logic [PWM_W-1:0]          pwm_sat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    mfbdr_chain #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_del       (in_xfer),
        .i_ins       (r_state == S_INS),
        .i_sample    (i_raw_sample),
        .i_ins_value (r_x),
        .o_median    (median)
    );

    always_comb begin
        rnd     = {1'b0, r_prod} + 30'd32768;
        scaled  = rnd[29:16];
        mv_wide = $signed({1'b0, scaled}) + $signed({{5{r_cal_offset[OFFSET_W-1]}}, r_cal_offset});
        if (mv_wide < 0) begin
            mv_sat = '0;
        end else if (mv_wide > $signed({3'b0, MV_MAX})) begin
            mv_sat = MV_MAX;
        end else begin
            mv_sat = mv_wide[SAMPLE_W-1:0];
        end
        err  = $signed({1'b0, r_setpoint}) - $signed({1'b0, mv_sat});
        gerr = err * $signed({1'b0, r_gain});
    end

    always_comb begin
        acc_sum = $signed({2'b0, r_acc}) + $signed({r_gerr[20], r_gerr});
        if (acc_sum > $signed({2'b0, r_duty_max})) begin
            acc_clamp = r_duty_max;
        end else begin
            acc_clamp = acc_sum[DUTY_W-1:0];
        end
        if (acc_sum < $signed({2'b0, r_duty_min}) || acc_clamp < r_duty_min) begin
            acc_clamp = r_duty_min;
        end
    end

    always_comb begin
        recip_prod = r_acc * DUTY_RECIP;
        q_back     = {9'b0, r_q0} * {10'b0, DUTY_DIV};
        rem        = r_acc - q_back;
        q_full     = r_q0 + 11'(rem >= {10'b0, DUTY_DIV});
        pwm_sat    = (q_full > {1'b0, PWM_MAX}) ? PWM_MAX : q_full[PWM_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_INS;
                end
            end
            S_INS:  n_state = S_MED;
            S_MED:  n_state = S_ERR;
            S_ERR:  n_state = S_ACC;
            S_ACC:  n_state = S_DIV;
            S_DIV:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_acc        <= DUTY_MIN_RST;
            r_setpoint   <= SETPOINT_RST;
            r_gain       <= GAIN_RST;
            r_duty_min   <= DUTY_MIN_RST;
            r_duty_max   <= DUTY_MAX_RST;
            r_cal_slope  <= SLOPE_RST;
            r_cal_offset <= OFFSET_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ACC) begin
                r_acc <= acc_clamp;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SETPOINT:   r_setpoint   <= i_cfg_data[SAMPLE_W-1:0];
                    REG_LOOP_GAIN:  r_gain       <= i_cfg_data[GAIN_W-1:0];
                    REG_DUTY_MIN:   r_duty_min   <= i_cfg_data[DUTY_W-1:0];
                    REG_DUTY_MAX:   r_duty_max   <= i_cfg_data[DUTY_W-1:0];
                    REG_CAL_SLOPE:  r_cal_slope  <= i_cfg_data[SLOPE_W-1:0];
                    REG_CAL_OFFSET: r_cal_offset <= i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= i_raw_sample;
        end
        if (r_state == S_MED) begin
            r_prod <= median * r_cal_slope;
        end
        if (r_state == S_ERR) begin
            r_mv   <= mv_sat;
            r_gerr <= gerr;
        end
        if (r_state == S_DIV) begin
            r_q0 <= recip_prod[30:20];
        end
        if (r_state == S_OUT && out_free) begin
            r_pwm   <= pwm_sat;
            r_fb_mv <= r_mv;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pwm_duty    = r_pwm;
    assign o_feedback_mv = r_fb_mv;

    a_xfer_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_INS))
        else $error("accepted sample did not start the insert step");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    a_acc_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_acc >= r_duty_min))
        else $error("accumulator below lower clamp");

    a_quotient_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (q_back <= r_acc && rem < 20'd2000))
        else $error("reciprocal quotient off by more than one");

endmodule

>>> rtl/mfbdr_cell.sv
// One cell of the sorted window: a sorted slot and a tap of the sample delay line.
module mfbdr_cell
    import mfbdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic                i_lo_present,
    input  logic [SAMPLE_W-1:0] i_lo_value,
    input  logic                i_lo_empty,
    input  logic [SAMPLE_W-1:0] i_hi_value,
    input  logic                i_hi_empty,
    input  logic [SAMPLE_W-1:0] i_tap,
    output logic [SAMPLE_W-1:0] o_value,
    output logic                o_empty,
    output logic [SAMPLE_W-1:0] o_tap
);

    logic [SAMPLE_W-1:0] r_value, n_value;
    logic                r_empty, n_empty;
    logic [SAMPLE_W-1:0] r_tap, n_tap;

    always_comb begin
        n_value = r_value;
        n_empty = r_empty;
        n_tap   = r_tap;
        if (i_cmd.del) begin
            n_tap = i_tap;
            if (!r_empty && r_value >= i_cmd.d && (i_hi_empty || i_hi_value > i_cmd.d)) begin
                n_value = i_hi_value;
                n_empty = i_hi_empty;
            end
        end else if (i_cmd.ins) begin
            if (r_empty || r_value > i_cmd.x) begin
                if (!i_lo_present || (!i_lo_empty && i_lo_value <= i_cmd.x)) begin
                    n_value = i_cmd.x;
                    n_empty = 1'b0;
                end else begin
                    n_value = i_lo_value;
                    n_empty = i_lo_empty;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_empty <= 1'b0;
            r_tap   <= '0;
        end else begin
            r_value <= n_value;
            r_empty <= n_empty;
            r_tap   <= n_tap;
        end
    end

    assign o_value = r_value;
    assign o_empty = r_empty;
    assign o_tap   = r_tap;

endmodule

>>> rtl/mfbdr_chain.sv
// Row of sorting cells holding the sample window, with oldest tap and median.
module mfbdr_chain
    import mfbdr_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_del,
    input  logic                i_ins,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_ins_value,
    output logic [SAMPLE_W-1:0] o_median
);

    localparam int MID = WINDOW_SIZE / 2;

    logic [SAMPLE_W-1:0] w_value [WINDOW_SIZE];
    logic                w_empty [WINDOW_SIZE];
    logic [SAMPLE_W-1:0] w_tap   [WINDOW_SIZE];
    t_cell_cmd           w_cmd;

    assign w_cmd.del = i_del;
    assign w_cmd.ins = i_ins;
    assign w_cmd.d   = w_tap[WINDOW_SIZE-1];
    assign w_cmd.x   = i_ins_value;

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        logic                lo_present;
        logic [SAMPLE_W-1:0] lo_value;
        logic                lo_empty;
        logic [SAMPLE_W-1:0] hi_value;
        logic                hi_empty;
        logic [SAMPLE_W-1:0] tap_in;

        if (g == 0) begin : g_bottom
            assign lo_present = 1'b0;
            assign lo_value   = '0;
            assign lo_empty   = 1'b0;
            assign tap_in     = i_sample;
        end else begin : g_lower
            assign lo_present = 1'b1;
            assign lo_value   = w_value[g-1];
            assign lo_empty   = w_empty[g-1];
            assign tap_in     = w_tap[g-1];
        end

        if (g == WINDOW_SIZE - 1) begin : g_top
            assign hi_value = '0;
            assign hi_empty = 1'b1;
        end else begin : g_upper
            assign hi_value = w_value[g+1];
            assign hi_empty = w_empty[g+1];
        end

        mfbdr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_lo_present (lo_present),
            .i_lo_value   (lo_value),
            .i_lo_empty   (lo_empty),
            .i_hi_value   (hi_value),
            .i_hi_empty   (hi_empty),
            .i_tap        (tap_in),
            .o_value      (w_value[g]),
            .o_empty      (w_empty[g]),
            .o_tap        (w_tap[g])
        );
    end

    if ((WINDOW_SIZE % 2) == 0) begin : g_even
        logic [SAMPLE_W:0] mid_sum;
        assign mid_sum  = {1'b0, w_value[MID]} + {1'b0, w_value[MID-1]};
        assign o_median = mid_sum[SAMPLE_W:1];
    end else begin : g_odd
        assign o_median = w_value[MID];
    end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the median-filtered boost duty regulator.
`timescale 1ns / 1ps

module testbench;
    import mfbdr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int WIN = WINDOW_SIZE_DEF;

    typedef struct packed {
        logic [PWM_W-1:0]    pwm;
        logic [SAMPLE_W-1:0] mv;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_raw_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PWM_W-1:0]      o_pwm_duty;
    logic [SAMPLE_W-1:0]   o_feedback_mv;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [SAMPLE_W-1:0]        m_setpoint = SETPOINT_RST;
    logic [GAIN_W-1:0]          m_gain = GAIN_RST;
    logic [DUTY_W-1:0]          m_duty_min = DUTY_MIN_RST;
    logic [DUTY_W-1:0]          m_duty_max = DUTY_MAX_RST;
    logic [SLOPE_W-1:0]         m_slope = SLOPE_RST;
    logic signed [OFFSET_W-1:0] m_offset = OFFSET_RST;
    logic [SAMPLE_W-1:0]        m_window [WIN];
    int                         m_wpos = 0;
    logic [DUTY_W-1:0]          m_duty_acc = DUTY_MIN_RST;

    t_reading pending_readings [$];
    int       err_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       drain_first = 1'b0;

    median_filtered_boost_duty_regulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_raw_sample  (i_raw_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pwm_duty    (o_pwm_duty),
        .o_feedback_mv (o_feedback_mv),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            REG_SETPOINT:   m_setpoint = data[SAMPLE_W-1:0];
            REG_LOOP_GAIN:  m_gain = data[GAIN_W-1:0];
            REG_DUTY_MIN:   m_duty_min = data[DUTY_W-1:0];
            REG_DUTY_MAX:   m_duty_max = data[DUTY_W-1:0];
            REG_CAL_SLOPE:  m_slope = data[SLOPE_W-1:0];
            REG_CAL_OFFSET: m_offset = data[OFFSET_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_reading predict_regulation(input logic [SAMPLE_W-1:0] sample);
        logic [SAMPLE_W-1:0] sorted [WIN];
        logic [SAMPLE_W-1:0] key;
        logic [SAMPLE_W:0]   pair_sum;
        logic [SAMPLE_W-1:0] median;
        longint              mv;
        longint              acc;
        longint              pwm;
        int                  i;
        int                  j;
        t_reading            r;
        m_window[m_wpos] = sample;
        m_wpos = (m_wpos == WIN - 1) ? 0 : m_wpos + 1;
        sorted = m_window;
        for (i = 1; i < WIN; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        if (WIN % 2 == 0) begin
            pair_sum = {1'b0, sorted[WIN / 2]} + {1'b0, sorted[WIN / 2 - 1]};
            median = pair_sum[SAMPLE_W:1];
        end else begin
            median = sorted[WIN / 2];
        end
        mv = ((longint'(median) * longint'(m_slope) + 32768) >>> 16) + longint'(m_offset);
        if (mv < 0) mv = 0;
        if (mv > 4095) mv = 4095;
        acc = longint'(m_duty_acc) + longint'(m_gain) * (longint'(m_setpoint) - mv);
        if (acc > longint'(m_duty_max)) acc = longint'(m_duty_max);
        if (acc < longint'(m_duty_min)) acc = longint'(m_duty_min);
        m_duty_acc = acc[DUTY_W-1:0];
        pwm = longint'(m_duty_acc) / 1000;
        if (pwm > 1023) pwm = 1023;
        r.pwm = pwm[PWM_W-1:0];
        r.mv = mv[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t unexpected transfer: pwm_duty %0d feedback_mv %0d",
                         $time, o_pwm_duty, o_feedback_mv);
                err_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_pwm_duty !== want.pwm) begin
                    $display("%0t pwm_duty expected %0d actual %0d",
                             $time, want.pwm, o_pwm_duty);
                    err_count++;
                end
                if (o_feedback_mv !== want.mv) begin
                    $display("%0t feedback_mv expected %0d actual %0d",
                             $time, want.mv, o_feedback_mv);
                    err_count++;
                end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        bit hold;
        @(negedge i_clk);
        forever begin
            hold = (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                || (drain_first && pending_readings.size() != 0);
            if (!hold) break;
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(predict_regulation(sample));
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int center);
        int v;
        case ($urandom_range(19))
            0, 1:    v = $urandom_range(1) ? 4095 : 0;
            2:       v = $urandom_range(1) ? 12'hAAA : 12'h555;
            3, 4, 5, 6, 7: v = $urandom_range(4095);
            default: v = center + $urandom_range(80) - 40;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic randomize_config(input int phase);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        lo = 20'($urandom_range(1024000));
        hi = 20'($urandom_range(1024000));
        if (lo > hi && $urandom_range(3) != 0) {lo, hi} = {hi, lo};
        if (phase == 3) begin
            lo = '0;
            hi = '1;
        end
        write_reg(REG_SETPOINT, 20'($urandom_range(20'hFFFFF)));
        write_reg(REG_LOOP_GAIN, (phase == 6) ? 20'hFF : 20'($urandom_range(20'hFFFFF)));
        write_reg(REG_DUTY_MIN, lo);
        write_reg(REG_DUTY_MAX, hi);
        write_reg(REG_CAL_SLOPE, $urandom_range(2) == 0 ? 20'($urandom_range(20'hFFFFF))
                                 : 20'(17604 + $urandom_range(4000) - 2000));
        write_reg(REG_CAL_OFFSET, 20'($urandom_range(20'hFFFFF)));
        if (phase == 1) write_reg(REG_CAL_SLOPE, 20'h1FFFF);
        if (phase == 5) write_reg(REG_CAL_SLOPE, 20'h0);
    endtask

    task automatic test_first_pass();
        logic [SAMPLE_W-1:0] pattern [18] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555,
            12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h800, 12'h7FF, 12'h001, 12'hFFE,
            12'hFFF, 12'h123, 12'hFFF, 12'hFFF, 12'h000, 12'h555};
        foreach (pattern[k]) send_sample(pattern[k]);
        settle_idle();
    endtask

    task automatic test_saturation();
        write_reg(REG_SETPOINT, 20'hFFFFF);
        write_reg(REG_LOOP_GAIN, 20'hFFFFF);
        write_reg(REG_DUTY_MIN, 20'h0);
        write_reg(REG_DUTY_MAX, 20'hFFFFF);
        write_reg(REG_CAL_SLOPE, 20'h0);
        write_reg(REG_CAL_OFFSET, 20'h0);
        repeat (2) send_sample(12'hFFF);
        settle_idle();
        write_reg(REG_SETPOINT, 20'hFF000);
        write_reg(REG_CAL_SLOPE, 20'h1FFFF);
        write_reg(REG_CAL_OFFSET, 20'h001FF);
        repeat (3) send_sample(12'hFFF);
        settle_idle();
        write_reg(REG_CAL_SLOPE, 20'h0);
        write_reg(REG_CAL_OFFSET, 20'h00200);
        repeat (2) send_sample(12'h000);
        settle_idle();
    endtask

    task automatic test_clamp_order();
        write_reg(REG_DUTY_MIN, 20'hFFFFF);
        write_reg(REG_DUTY_MAX, 20'h0);
        write_reg(REG_CAL_SLOPE, 20'h1FFFF);
        write_reg(REG_SPARE_A, 20'hFFFFF);
        write_reg(REG_SPARE_B, 20'h00000);
        repeat (2) send_sample(12'h7FF);
        settle_idle();
    endtask

    task automatic test_random_regulation();
        int center;
        for (int phase = 0; phase < 8; phase++) begin
            randomize_config(phase);
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(51, 0);
                2: set_idling(0, 51);
                default: set_idling(18, 18);
            endcase
            center = $urandom_range(4095);
            repeat (135) send_sample(pick_sample(center));
            settle_idle();
        end
        set_idling(0, 0);
    endtask

    task automatic test_drain_pressure();
        set_idling(18, 51);
        drain_first = 1'b1;
        repeat (40) send_sample(12'($urandom_range(4095)));
        drain_first = 1'b0;
        set_idling(0, 0);
        settle_idle();
    endtask

    initial begin
        foreach (m_window[k]) m_window[k] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        test_first_pass();
        test_saturation();
        test_clamp_order();
        test_random_regulation();
        test_drain_pressure();
        settle_idle();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[median_filtered_boost_duty_regulator] OK");
        end else begin
            $display("[median_filtered_boost_duty_regulator] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[median_filtered_boost_duty_regulator] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mfbdr_pkg.sv
rtl/mfbdr_cell.sv
rtl/mfbdr_chain.sv
rtl/median_filtered_boost_duty_regulator.sv
dv/testbench.sv
